[rtl/core/swsfd_pkg.sv]
// ---------------------------------------------------------------------------
// Single-wire sensor frame decoder package
// Shared constants, register map, request codes and structs.
// ---------------------------------------------------------------------------
`default_nettype none

package swsfd_pkg;

   // Frame layout
   localparam int FRAME_BITS   = 40;
   localparam int FRAME_IDX_W  = $clog2(FRAME_BITS);
   localparam int BIT_COUNT_W  = $clog2(FRAME_BITS + 1);
   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 16;

   // Timer width default, and width of the timing registers
   localparam int TIME_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH          = 16;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] GAP_RESET   = CFG_WIDTH'(100);
   localparam logic [CFG_WIDTH-1:0] START_RESET = CFG_WIDTH'(250);

   // Control/status port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_GAP   = 1'b0;
   localparam logic CSR_IDX_START = 1'b1;

   // Request codes carried on the input tuser
   localparam int REQ_TYPE_W = 2;
   localparam logic [REQ_TYPE_W-1:0] REQ_START   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_EDGE    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TIMEOUT = 2'd2;

   // Result packing on the output tdata
   localparam int RSP_FIELDS_W = WORD_W + WORD_W + 1 + BIT_COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] one_bit_gap;
      logic [CFG_WIDTH-1:0] data_start_time;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [FRAME_BITS-1:0]  frame;
      logic [BIT_COUNT_W-1:0] count;
      logic                   timed_out;
   } frame_event_type;

   typedef struct packed {
      logic                   armed;
      logic [BIT_COUNT_W-1:0] bit_count;
   } capture_status_type;

   typedef struct packed {
      logic [BIT_COUNT_W-1:0] bits_received;
      logic                   checksum_ok;
      logic signed [WORD_W-1:0] temperature;
      logic [WORD_W-1:0]      humidity;
      logic                   timed_out;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/swsfd_csr.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style access to the bit threshold and the data start time.
// ---------------------------------------------------------------------------
`default_nettype none

module swsfd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [swsfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [swsfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [swsfd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output swsfd_pkg::cfg_type                     cfg
);
   import swsfd_pkg::*;

   logic [CFG_WIDTH-1:0] gap_ff, gap_in;
   logic [CFG_WIDTH-1:0] start_ff, start_in;
   logic                 wr_en;
   logic                 reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      gap_in   = gap_ff;
      start_in = start_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_IDX_GAP:   gap_in   = csr_pwdata[CFG_WIDTH-1:0];
            CSR_IDX_START: start_in = csr_pwdata[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         start_ff <= START_RESET;
      end else begin
         gap_ff   <= gap_in;
         start_ff <= start_in;
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_IDX_GAP:   csr_prdata = CSR_DATA_W'(gap_ff);
         CSR_IDX_START: csr_prdata = CSR_DATA_W'(start_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.one_bit_gap     = gap_ff;
   assign cfg.data_start_time = start_ff;

endmodule

`default_nettype wire

[rtl/core/swsfd_capture.sv]
// ---------------------------------------------------------------------------
// Frame capture
// Turns edge timestamps into frame bits and raises a frame event at the
// fortieth bit or on a timeout while armed.
// ---------------------------------------------------------------------------
`default_nettype none

module swsfd_capture #(
   parameter int TIME_WIDTH = swsfd_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [swsfd_pkg::REQ_TYPE_W-1:0]   req_type,
   input  wire logic [TIME_WIDTH-1:0]              edge_time,
   input  swsfd_pkg::cfg_type                      cfg,
   output swsfd_pkg::frame_event_type              evt,
   output swsfd_pkg::capture_status_type           status
);
   import swsfd_pkg::*;

   localparam int CMP_W = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

   logic                   armed_ff, armed_in;
   logic [BIT_COUNT_W-1:0] count_ff, count_in;
   logic [TIME_WIDTH-1:0]  prev_ff, prev_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;

   logic [TIME_WIDTH-1:0]  gap;
   logic                   bit_val;
   logic                   past_preamble;
   logic [FRAME_IDX_W-1:0] bit_idx;

   // The gap wraps with the timer, so a plain modular subtract is enough.
   assign gap           = edge_time - prev_ff;
   assign bit_val       = CMP_W'(gap) > CMP_W'(cfg.one_bit_gap);
   assign past_preamble = CMP_W'(edge_time) > CMP_W'(cfg.data_start_time);
   assign bit_idx       = FRAME_IDX_W'(FRAME_BITS - 1) - count_ff[FRAME_IDX_W-1:0];

   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      prev_in  = prev_ff;
      frame_in = frame_ff;
      evt      = '0;
      if (accept) begin
         case (req_type)
            REQ_START: begin
               armed_in = 1'b1;
               count_in = '0;
               prev_in  = '0;
               frame_in = '0;
            end
            REQ_EDGE: begin
               if (armed_ff) begin
                  prev_in = edge_time;
                  if (past_preamble && (count_ff < BIT_COUNT_W'(FRAME_BITS))) begin
                     frame_in[bit_idx] = bit_val;
                     count_in          = count_ff + BIT_COUNT_W'(1);
                     if (count_in == BIT_COUNT_W'(FRAME_BITS)) begin
                        armed_in      = 1'b0;
                        evt.valid     = 1'b1;
                        evt.frame     = frame_in;
                        evt.count     = count_in;
                        evt.timed_out = 1'b0;
                     end
                  end
               end
            end
            REQ_TIMEOUT: begin
               if (armed_ff) begin
                  armed_in      = 1'b0;
                  evt.valid     = 1'b1;
                  evt.frame     = frame_ff;
                  evt.count     = count_ff;
                  evt.timed_out = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

   // Only read while armed, and a start clears them first.
   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      frame_ff <= frame_in;
   end

   assign status.armed     = armed_ff;
   assign status.bit_count = count_ff;

endmodule

`default_nettype wire

[rtl/core/swsfd_convert.sv]
// ---------------------------------------------------------------------------
// Frame conversion
// Splits a finished frame into humidity and temperature, turns the
// sign-magnitude temperature into two's complement and checks the checksum.
// ---------------------------------------------------------------------------
`default_nettype none

module swsfd_convert (
   input  swsfd_pkg::frame_event_type evt,
   output swsfd_pkg::result_type      result
);
   import swsfd_pkg::*;

   logic [WORD_W-1:0]   raw_temp;
   logic [WORD_W-1:0]   magnitude;
   logic [BYTE_W-1:0]   byte_sum;

   assign raw_temp  = evt.frame[23:8];
   assign magnitude = {1'b0, raw_temp[WORD_W-2:0]};
   assign byte_sum  = evt.frame[39:32] + evt.frame[31:24] + evt.frame[23:16]
                    + evt.frame[15:8];

   always_comb begin
      result.humidity      = evt.frame[39:24];
      // A set sign bit with zero magnitude negates to zero.
      result.temperature   = raw_temp[WORD_W-1] ? $signed(-magnitude)
                                                : $signed(magnitude);
      result.checksum_ok   = (byte_sum == evt.frame[7:0]);
      result.timed_out     = evt.timed_out;
      result.bits_received = evt.count;
   end

endmodule

`default_nettype wire

[rtl/core/swsfd_outq.sv]
// ---------------------------------------------------------------------------
// Result output stage
// Output register with one skid entry, so a new item can be taken while a
// result waits on the consumer.
// ---------------------------------------------------------------------------
`default_nettype none

module swsfd_outq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  swsfd_pkg::result_type push_data,
   output logic                  can_accept,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output swsfd_pkg::result_type out_data
);
   import swsfd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type rsp_ff, rsp_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop        = rsp_valid_ff & out_ready;
   assign can_accept = ~skid_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // No push is possible here: the input side is stalled.
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = push_data;
            rsp_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/single_wire_sensor_frame_decoder_top.sv]
// ---------------------------------------------------------------------------
// Single-wire sensor frame decoder
// Decodes a 40-bit humidity/temperature frame from rising-edge timestamps.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Moves
//  req_     in         tvalid/tready             start, edge or timeout request
//  rsp_     out        tvalid/tready             decoded frame, one per frame
//  csr_     in         psel/penable, pready=1    bit threshold, data start time
//
//  A request is taken in the cycle it is offered, one per clock, while the
//  output stage has room.
//  A finished frame's result is registered in the output or the skid entry.
//  The output register plus one skid entry hold results; req_tready drops
//  only while both are occupied.
//  Reset clears the armed flag, the bit count and the output stage; the
//  registers return to a threshold of 100 and a start time of 250 ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module single_wire_sensor_frame_decoder_top #(
   parameter int TIME_WIDTH = swsfd_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   // Request channel
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   // tdata: edge_time, zero padded to whole bytes
   input  wire logic [((TIME_WIDTH + 7) / 8) * 8 - 1:0]    req_tdata,
   // tuser: req_type
   input  wire logic [swsfd_pkg::REQ_TYPE_W-1:0]           req_tuser,
   // Result channel
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   // tdata: humidity[15:0], temperature[31:16], checksum_ok[32],
   //        bits_received[38:33], zero pad [39]
   output logic [swsfd_pkg::RSP_DATA_W-1:0]                rsp_tdata,
   // tuser: timed_out
   output logic                                            rsp_tuser,
   // Configuration port
   input  wire logic                                       csr_psel,
   input  wire logic                                       csr_penable,
   input  wire logic                                       csr_pwrite,
   input  wire logic [swsfd_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  wire logic [swsfd_pkg::CSR_DATA_W-1:0]           csr_pwdata,
   output logic      [swsfd_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                            csr_pready
);
   import swsfd_pkg::*;

   cfg_type            cfg;
   frame_event_type    evt;
   capture_status_type status;
   result_type         conv_result;
   result_type         out_result;
   logic               req_accept;

   assign req_accept = req_tvalid & req_tready;

   swsfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swsfd_capture #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_capture (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req_type  (req_tuser),
      .edge_time (req_tdata[TIME_WIDTH-1:0]),
      .cfg       (cfg),
      .evt       (evt),
      .status    (status)
   );

   swsfd_convert u_convert (
      .evt    (evt),
      .result (conv_result)
   );

   swsfd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (evt.valid),
      .push_data  (conv_result),
      .can_accept (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_result)
   );

   assign rsp_tdata = RSP_DATA_W'({out_result.bits_received,
                                   out_result.checksum_ok,
                                   out_result.temperature,
                                   out_result.humidity});
   assign rsp_tuser = out_result.timed_out;

   // An accepted start always arms capture with an empty frame.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == REQ_START)
         |=> (status.armed && status.bit_count == '0))
      else $error("start request did not arm capture");

   // A frame event is only raised while the output stage has room.
   assert property (@(posedge clock) disable iff (reset)
      evt.valid |-> req_tready)
      else $error("frame event raised with output stage full");

   // Complete frames carry forty bits; timeouts always carry fewer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser)
         |-> (out_result.bits_received == BIT_COUNT_W'(FRAME_BITS)))
      else $error("complete frame result without forty bits");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser)
         |-> (out_result.bits_received < BIT_COUNT_W'(FRAME_BITS)))
      else $error("timeout result with a full frame");

endmodule

`default_nettype wire
